// ----- hdl/assert_macros.svh -----
// Assertion helper macros for the cache unit.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Check an implication on every clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Check that the consequent holds in the cycle after the antecedent.
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

// ----- hdl/bblc_pkg.sv -----
// ----------------------------------------------------------------------------
// bblc_pkg
// Types, constants and command structs for the byte budget LRU cache.
// ----------------------------------------------------------------------------
package bblc_pkg;
  localparam int ENTRIES = 16;
  localparam int IDX_W = $clog2(ENTRIES);
  localparam int CNT_W = $clog2(ENTRIES + 1);
  localparam int BYTES_W = 26;
  localparam int TAG_W = 32;
  localparam logic [BYTES_W-1:0] HARD_LIMIT = 26'd33554432;
  localparam logic [BYTES_W-1:0] BUDGET_RESET = 26'd33554432;

  typedef enum logic [1:0] {
    OUT_HIT = 2'd0, OUT_INSERTED = 2'd1, OUT_TOO_LARGE = 2'd2, OUT_DECODE_FAIL = 2'd3
  } outcome_t;

  typedef struct packed {
    logic [TAG_W-1:0] key_tag;
    logic [BYTES_W-1:0] entry_bytes;
    logic decode_ok;
  } in_item_t;

  typedef struct packed {
    logic [1:0] outcome;
    logic [4:0] evicted_count;
    logic [BYTES_W-1:0] used_bytes;
    logic [BYTES_W-1:0] peak_bytes;
    logic [4:0] entry_count;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_LOOKUP, ST_EVICT, ST_INSERT, ST_DONE
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic load;
    logic do_hit;
    logic do_evict;
    logic do_insert;
    logic emit;
    logic [1:0] outcome;
  } dp_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic hit;
    logic decode_ok;
    logic too_large;
    logic need_evict;
  } dp_stat_t;
endpackage

// ----- hdl/bblc_ctrl.sv -----
// ----------------------------------------------------------------------------
// bblc_ctrl
// Request sequencer: lookup, evict loop, insert, result strobe.
// ----------------------------------------------------------------------------
module bblc_ctrl import bblc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);
  state_t state_r, state_nxt;
  logic [1:0] oc_r, oc_nxt;

  // Hold state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      oc_r <= OUT_HIT;
    end else begin
      state_r <= state_nxt;
      oc_r <= oc_nxt;
    end
  end

  // Sequence one request.
  always_comb begin
    state_nxt = state_r;
    oc_nxt = oc_r;
    cmd = '0;
    cmd.outcome = oc_r;
    busy = (state_r != ST_IDLE);
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load = 1'b1;
          state_nxt = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        if (stat.hit) begin
          cmd.do_hit = 1'b1;
          oc_nxt = OUT_HIT;
          state_nxt = ST_DONE;
        end else if (!stat.decode_ok) begin
          oc_nxt = OUT_DECODE_FAIL;
          state_nxt = ST_DONE;
        end else if (stat.too_large) begin
          oc_nxt = OUT_TOO_LARGE;
          state_nxt = ST_DONE;
        end else begin
          oc_nxt = OUT_INSERTED;
          state_nxt = ST_EVICT;
        end
      end
      ST_EVICT: begin
        if (stat.need_evict) cmd.do_evict = 1'b1;
        else state_nxt = ST_INSERT;
      end
      ST_INSERT: begin
        cmd.do_insert = 1'b1;
        state_nxt = ST_DONE;
      end
      ST_DONE: begin
        cmd.emit = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end
endmodule

// ----- hdl/bblc_dp.sv -----
// ----------------------------------------------------------------------------
// bblc_dp
// Entry table, recency ranks, byte totals and result register.
// ----------------------------------------------------------------------------
module bblc_dp import bblc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  in_item_t           in_data,
  input  logic               cfg_we,
  input  logic [BYTES_W-1:0] cfg_data,
  input  dp_cmd_t            cmd,
  output dp_stat_t           stat,
  output logic               out_strobe,
  output out_item_t          out_data
);
  logic [ENTRIES-1:0] valid_r, valid_nxt;
  logic [TAG_W-1:0]   tag_r  [ENTRIES];
  logic [BYTES_W-1:0] size_r [ENTRIES];
  logic [IDX_W-1:0]   rank_r [ENTRIES];
  logic [BYTES_W-1:0] total_r, peak_r, budget_r;
  logic [CNT_W-1:0]   count_r;
  logic [4:0]         evict_r;
  in_item_t           req_r;
  logic               strobe_r;
  out_item_t          out_r;

  logic [BYTES_W-1:0] eff_budget;
  logic               hit_c;
  logic [IDX_W-1:0]   hit_idx_c, old_idx_c, free_idx_c;
  logic [BYTES_W:0]   sum_c;

  assign eff_budget = (budget_r < HARD_LIMIT) ? budget_r : HARD_LIMIT;
  assign sum_c = {1'b0, total_r} + {1'b0, req_r.entry_bytes};

  // Match tag, find the least recent entry and a free slot.
  always_comb begin
    hit_c = 1'b0;
    hit_idx_c = '0;
    old_idx_c = '0;
    free_idx_c = '0;
    for (int i = ENTRIES - 1; i >= 0; i--) begin
      if (valid_r[i] && tag_r[i] == req_r.key_tag) begin
        hit_c = 1'b1;
        hit_idx_c = IDX_W'(i);
      end
      if (valid_r[i] && {1'b0, rank_r[i]} == count_r - CNT_W'(1)) old_idx_c = IDX_W'(i);
      if (!valid_r[i]) free_idx_c = IDX_W'(i);
    end
  end

  assign stat.hit = hit_c;
  assign stat.decode_ok = req_r.decode_ok;
  assign stat.too_large = req_r.entry_bytes > eff_budget;
  assign stat.need_evict = (count_r != '0) &&
                           ((sum_c > {1'b0, eff_budget}) || (count_r == CNT_W'(ENTRIES)));

  // Update control state.
  always_comb begin
    valid_nxt = valid_r;
    if (cmd.do_evict) valid_nxt[old_idx_c] = 1'b0;
    if (cmd.do_insert) valid_nxt[free_idx_c] = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
      total_r <= '0;
      peak_r <= '0;
      count_r <= '0;
      budget_r <= BUDGET_RESET;
      strobe_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
      strobe_r <= cmd.emit;
      if (cfg_we) budget_r <= cfg_data;
      if (cmd.do_evict) begin
        total_r <= total_r - size_r[old_idx_c];
        count_r <= count_r - CNT_W'(1);
      end
      if (cmd.do_insert) begin
        total_r <= sum_c[BYTES_W-1:0];
        count_r <= count_r + CNT_W'(1);
        if (sum_c[BYTES_W-1:0] > peak_r) peak_r <= sum_c[BYTES_W-1:0];
      end
    end
  end

  // Capture request, ranks, result.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_data;
      evict_r <= '0;
    end
    if (cmd.do_evict) evict_r <= evict_r + 5'd1;
    for (int i = 0; i < ENTRIES; i++) begin
      if (cmd.do_hit && valid_r[i] && rank_r[i] < rank_r[hit_idx_c])
        rank_r[i] <= rank_r[i] + IDX_W'(1);
      if (cmd.do_insert && valid_r[i]) rank_r[i] <= rank_r[i] + IDX_W'(1);
    end
    if (cmd.do_hit) rank_r[hit_idx_c] <= '0;
    if (cmd.do_insert) begin
      tag_r[free_idx_c] <= req_r.key_tag;
      size_r[free_idx_c] <= req_r.entry_bytes;
      rank_r[free_idx_c] <= '0;
    end
    if (cmd.emit) begin
      out_r.outcome <= cmd.outcome;
      out_r.evicted_count <= evict_r;
      out_r.used_bytes <= total_r;
      out_r.peak_bytes <= peak_r;
      out_r.entry_count <= 5'(count_r);
    end
  end

  assign out_strobe = strobe_r;
  assign out_data = out_r;
endmodule

// ----- hdl/byte_budget_lru_cache_unit.sv -----
// ----------------------------------------------------------------------------
// byte_budget_lru_cache_unit
// LRU cache of 16 variable-sized entries under a clamped byte budget.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Its result appears
// on out_data with out_strobe, high for a single cycle; the receiver cannot
// stall, so it must take every strobe. A hit, a decode failure or a too-large
// miss goes from lookup to the done state; an insert runs the evict loop, one
// eviction per cycle while the entry does not fit or the table is full, then
// the insert state. The budget register may be written whenever busy is low.
`include "assert_macros.svh"
module byte_budget_lru_cache_unit import bblc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  output logic               busy,
  input  in_item_t           in_data,
  output logic               out_strobe,
  output out_item_t          out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [BYTES_W-1:0] cfg_data
);
  dp_cmd_t  cmd;
  dp_stat_t stat;

  assign cfg_ready = 1'b1;

  bblc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .stat(stat), .cmd(cmd)
  );

  bblc_dp u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data), .cfg_we(cfg_valid && cfg_ready),
    .cfg_data(cfg_data), .cmd(cmd), .stat(stat), .out_strobe(out_strobe),
    .out_data(out_data)
  );

  `CHK_NEXT(a_start_busy, clk, rst_n, start && !busy, busy, "accepted start did not raise busy")
  `CHK_IMPL(a_strobe_idle, clk, rst_n, out_strobe, !busy, "result strobe while busy")
  `CHK_IMPL(a_count_range, clk, rst_n, out_strobe, out_data.entry_count <= 5'd16, "bad count")
endmodule

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the byte budget LRU cache unit. A directed table,
// then random tag traffic from a small tag pool, is checked against an
// in-bench model of the cache, with the budget changed between phases.
// ----------------------------------------------------------------------------
module tb_top;
  import bblc_pkg::*;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_item_t in_data;
  logic out_strobe;
  out_item_t out_data;
  logic cfg_valid;
  logic cfg_ready;
  logic [BYTES_W-1:0] cfg_data;

  byte_budget_lru_cache_unit dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_data(in_data),
    .out_strobe(out_strobe), .out_data(out_data), .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  // Cache model state
  logic              line_valid [ENTRIES];
  logic [TAG_W-1:0]  line_tag [ENTRIES];
  logic [BYTES_W:0]  line_size [ENTRIES];
  int                line_rank [ENTRIES];
  logic [BYTES_W:0]  held_bytes;
  logic [BYTES_W:0]  peak_held;
  logic [BYTES_W-1:0] budget_reg;

  out_item_t expected_q[$];
  int mismatches;

  typedef struct {
    in_item_t  req;
    logic      has_exp;
    out_item_t exp;
  } dir_row_t;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Predict one request and update the cache model.
  function automatic out_item_t cache_lookup(in_item_t req);
    out_item_t res;
    int count;
    int hit;
    int r;
    int evicted;
    logic [BYTES_W:0] lim;
    count = 0;
    hit = -1;
    evicted = 0;
    for (int i = 0; i < ENTRIES; i++) if (line_valid[i]) count++;
    for (int i = 0; i < ENTRIES; i++)
      if (hit < 0 && line_valid[i] && line_tag[i] == req.key_tag) hit = i;
    lim = (budget_reg < HARD_LIMIT) ? budget_reg : HARD_LIMIT;
    if (hit >= 0) begin
      r = line_rank[hit];
      for (int i = 0; i < ENTRIES; i++)
        if (line_valid[i] && line_rank[i] < r) line_rank[i]++;
      line_rank[hit] = 0;
      res.outcome = OUT_HIT;
    end else if (!req.decode_ok) begin
      res.outcome = OUT_DECODE_FAIL;
    end else if (req.entry_bytes > lim) begin
      res.outcome = OUT_TOO_LARGE;
    end else begin
      // Evict oldest until the new entry fits and a slot is free
      while (count > 0 && (held_bytes > lim - req.entry_bytes || count >= ENTRIES)) begin
        for (int i = 0; i < ENTRIES; i++)
          if (line_valid[i] && line_rank[i] == count - 1) begin
            line_valid[i] = 1'b0;
            held_bytes = held_bytes - line_size[i];
          end
        count--;
        evicted++;
      end
      for (int i = 0; i < ENTRIES; i++) if (line_valid[i]) line_rank[i]++;
      for (int i = 0; i < ENTRIES; i++)
        if (!line_valid[i]) begin
          line_valid[i] = 1'b1;
          line_tag[i] = req.key_tag;
          line_size[i] = req.entry_bytes;
          line_rank[i] = 0;
          break;
        end
      count++;
      held_bytes = held_bytes + req.entry_bytes;
      if (held_bytes > peak_held) peak_held = held_bytes;
      res.outcome = OUT_INSERTED;
    end
    res.evicted_count = evicted[4:0];
    res.used_bytes = held_bytes[BYTES_W-1:0];
    res.peak_bytes = peak_held[BYTES_W-1:0];
    res.entry_count = count[4:0];
    return res;
  endfunction

  // Check each strobed result against the oldest expectation
  always @(posedge clk) begin
    out_item_t exp;
    if (rst_n && out_strobe) begin
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data);
      end else begin
        exp = expected_q.pop_front();
        if (out_data.outcome !== exp.outcome
            || out_data.evicted_count !== exp.evicted_count
            || out_data.used_bytes !== exp.used_bytes
            || out_data.peak_bytes !== exp.peak_bytes
            || out_data.entry_count !== exp.entry_count) begin
          mismatches++;
          if (mismatches <= 10) $display("mismatch: exp %p got %p", exp, out_data);
        end
      end
    end
  end

  // Send one request; the directed table may supply a typed expectation.
  // Start stays high after the transfer until a gap or a drain drops it.
  task automatic send_request(in_item_t req, logic has_exp, out_item_t typed);
    out_item_t pred;
    in_data <= req;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    pred = cache_lookup(req);
    if (has_exp && pred !== typed) begin
      mismatches++;
      if (mismatches <= 10) $display("table row disagrees: %p vs %p", typed, pred);
    end
    expected_q.push_back(has_exp ? typed : pred);
  endtask

  // Wait for all results, then let the sequencer finish before a write.
  task automatic drain;
    start <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  task automatic write_budget(logic [BYTES_W-1:0] value);
    cfg_data <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    budget_reg = value;
  endtask

  // Random traffic: mostly small tags and sizes, rare extremes.
  task automatic random_phase(int n, logic [BYTES_W-1:0] size_max);
    in_item_t req;
    int burst;
    burst = 0;
    for (int k = 0; k < n; k++) begin
      req.key_tag = ($urandom_range(0, 19) == 0) ? $urandom() : $urandom_range(0, 23);
      case ($urandom_range(0, 9))
        0: req.entry_bytes = BYTES_W'($urandom());
        1: req.entry_bytes = 0;
        default: req.entry_bytes = BYTES_W'($urandom_range(0, size_max));
      endcase
      req.decode_ok = ($urandom_range(0, 7) != 0);
      send_request(req, 1'b0, '0);
      // Hold off between bursts
      if (burst == 0) begin
        burst = $urandom_range(1, 12);
        if ($urandom_range(0, 2) != 0) begin
          start <= 1'b0;
          repeat ($urandom_range(1, 6)) @(posedge clk);
        end
      end
      burst--;
    end
  endtask

  // Stimulus
  initial begin
    dir_row_t rows[$];
    dir_row_t row;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    mismatches = 0;
    held_bytes = '0;
    peak_held = '0;
    budget_reg = BUDGET_RESET;
    for (int i = 0; i < ENTRIES; i++) begin
      line_valid[i] = 1'b0;
      line_rank[i] = 0;
    end
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed table: typed expectations where obvious
    row.has_exp = 1'b1;
    row.req = '{32'h0, 26'd100, 1'b0};
    row.exp = '{OUT_DECODE_FAIL, 5'd0, 26'd0, 26'd0, 5'd0};
    rows.push_back(row);
    row.req = '{32'hFFFF_FFFF, 26'h3FF_FFFF, 1'b1};
    row.exp = '{OUT_TOO_LARGE, 5'd0, 26'd0, 26'd0, 5'd0};
    rows.push_back(row);
    row.req = '{32'h0, 26'd0, 1'b1};
    row.exp = '{OUT_INSERTED, 5'd0, 26'd0, 26'd0, 5'd1};
    rows.push_back(row);
    row.req = '{32'h0, 26'h3FF_FFFF, 1'b0};
    row.exp = '{OUT_HIT, 5'd0, 26'd0, 26'd0, 5'd1};
    rows.push_back(row);
    row.req = '{32'hFFFF_FFFF, 26'd33554432, 1'b1};
    row.exp = '{OUT_INSERTED, 5'd0, 26'd33554432, 26'd33554432, 5'd2};
    rows.push_back(row);
    row.has_exp = 1'b0;
    row.req = '{32'h5, 26'd1, 1'b1};
    rows.push_back(row);
    for (int t = 10; t < 28; t++) begin
      row.req = '{TAG_W'(t), BYTES_W'(t), 1'b1};
      rows.push_back(row);
    end
    row.req = '{32'd12, 26'd0, 1'b1};
    rows.push_back(row);
    foreach (rows[i]) send_request(rows[i].req, rows[i].has_exp, rows[i].exp);
    drain();

    // Small budget: pressure evictions and too-large
    write_budget(26'd4000);
    random_phase(500, 26'd1500);
    drain();
    // Lower below the held total
    write_budget(26'd300);
    random_phase(300, 26'd400);
    drain();
    write_budget(26'd0);
    random_phase(100, 26'd4);
    drain();
    write_budget(26'h3FF_FFFF);
    random_phase(400, 26'h3FF_FFFF);
    drain();
    write_budget(26'd100000);
    random_phase(400, 26'd20000);
    drain();

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #20000000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
